// ===== sv/atc_pkg.sv =====
// shared types, constants and colour helpers for the atc block decoder
`default_nettype none
package atc_pkg;

  localparam int MAX_DIMENSION_DEF = 4096;
  localparam int CFG_W = 13;
  localparam int CFG_IDX_W = 2;
  localparam int COORD_W = 12;
  localparam int CHAN_W = 8;
  localparam int TEXELS = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_MODE = 2'd2;

  localparam logic [1:0] SEL_E0 = 2'd0;
  localparam logic [1:0] SEL_THIRD = 2'd1;
  localparam logic [1:0] SEL_EIGHTH = 2'd2;
  localparam logic [1:0] SEL_E1 = 2'd3;

  // floor(v/3) as (v*683)>>11, exact for v up to 765
  localparam logic [20:0] DIV3_RECIP = 21'd683;
  localparam int DIV3_SHIFT = 11;

  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [CHAN_W-1:0] ALPHA_SCALE = 8'd17;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     wdata;
  } cfg_wr_t;

  typedef struct packed {
    logic [63:0]         alpha_nibbles;
    logic [31:0]         selector_bits;
    logic [CHAN_W-1:0]   r0;
    logic [CHAN_W-1:0]   g0;
    logic [CHAN_W-1:0]   b0;
    logic [CHAN_W-1:0]   r1;
    logic [CHAN_W-1:0]   g1;
    logic [CHAN_W-1:0]   b1;
    logic [TEXELS-1:0]   mask;
    logic [COORD_W-1:0]  base_x;
    logic [COORD_W-1:0]  base_y;
    logic                explicit_alpha;
  } blk_entry_t;

  function automatic logic [CHAN_W-1:0] widen5(logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [CHAN_W-1:0] widen6(logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  function automatic logic [CHAN_W-1:0] blend(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b,
                                              logic [1:0] sel);
    logic [9:0]  s1;
    logic [20:0] p;
    logic [10:0] s2;
    logic [CHAN_W-1:0] res;
    s1 = {1'b0, a, 1'b0} + {2'b00, b};
    p = 21'(s1) * DIV3_RECIP;
    s2 = 11'(3 * 11'(a)) + 11'(5 * 11'(b));
    unique case (sel)
      SEL_E0:     res = a;
      SEL_THIRD:  res = p[DIV3_SHIFT +: CHAN_W];
      SEL_EIGHTH: res = s2[10:3];
      SEL_E1:     res = b;
      default:    res = a;
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== sv/atc_front.sv =====
// front end: configuration, block position tracking, edge mask and endpoint widening
`default_nettype none
module atc_front #(
  parameter int MAX_DIMENSION = atc_pkg::MAX_DIMENSION_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire atc_pkg::cfg_wr_t    cfg,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [63:0]         in_alpha_nibbles,
  input  wire logic [15:0]         in_endpoint_zero,
  input  wire logic [15:0]         in_endpoint_one,
  input  wire logic [31:0]         in_selector_bits,
  input  wire logic                q_full,
  output logic                     q_push,
  output atc_pkg::blk_entry_t      q_entry
);

  localparam int COL_RAW = $clog2((MAX_DIMENSION + 3) / 4);
  localparam int COL_W = (COL_RAW > 0) ? COL_RAW : 1;
  localparam int CNT_W = COL_W + 1;
  localparam int XW = COL_W + 3;

  logic [XW-1:0]    w_r, w_nxt, h_r, h_nxt;
  logic [CNT_W-1:0] bxc_r, bxc_nxt, byc_r, byc_nxt;
  logic             amode_r, amode_nxt;
  logic [COL_W-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [CNT_W-1:0] col_inc, row_inc;
  logic [3:0]       col_ok, row_ok;
  logic [atc_pkg::TEXELS-1:0] mask;
  logic             accept;

  function automatic logic [XW-1:0] clamp_dim(logic [atc_pkg::CFG_W-1:0] d);
    if (d == '0) return XW'(1);
    else if (32'(d) > 32'(MAX_DIMENSION)) return XW'(MAX_DIMENSION);
    else return XW'(d);
  endfunction

  function automatic logic [CNT_W-1:0] blocks_of(logic [XW-1:0] d);
    logic [XW:0] t;
    t = {1'b0, d} + (XW + 1)'(3);
    return CNT_W'(t >> 2);
  endfunction

  always_comb begin
    w_nxt = w_r;
    h_nxt = h_r;
    amode_nxt = amode_r;
    if (cfg.we) begin
      unique case (cfg.index)
        atc_pkg::CFG_IMAGE_WIDTH:  w_nxt = clamp_dim(cfg.wdata);
        atc_pkg::CFG_IMAGE_HEIGHT: h_nxt = clamp_dim(cfg.wdata);
        atc_pkg::CFG_ALPHA_MODE:   amode_nxt = cfg.wdata[0];
        default: ;
      endcase
    end
    bxc_nxt = blocks_of(w_nxt);
    byc_nxt = blocks_of(h_nxt);
  end

  assign in_ready = !q_full;
  assign accept = in_valid && in_ready;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      col_ok[i] = (XW'({col_r, 2'b00}) + XW'(i)) < w_r;
      row_ok[i] = (XW'({row_r, 2'b00}) + XW'(i)) < h_r;
    end
    for (int k = 0; k < atc_pkg::TEXELS; k++) begin
      mask[k] = col_ok[k % 4] && row_ok[k / 4];
    end
  end

  always_comb begin
    col_inc = {1'b0, col_r} + CNT_W'(1);
    row_inc = {1'b0, row_r} + CNT_W'(1);
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_inc >= bxc_r) begin
        col_nxt = '0;
        row_nxt = (row_inc >= byc_r) ? '0 : COL_W'(row_inc);
      end else begin
        col_nxt = COL_W'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= XW'(4);
      h_r <= XW'(4);
      bxc_r <= CNT_W'(1);
      byc_r <= CNT_W'(1);
      amode_r <= 1'b0;
      col_r <= '0;
      row_r <= '0;
    end else begin
      w_r <= w_nxt;
      h_r <= h_nxt;
      bxc_r <= bxc_nxt;
      byc_r <= byc_nxt;
      amode_r <= amode_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // fully clipped blocks only move the counters
  assign q_push = accept && (mask != '0);

  always_comb begin
    q_entry.alpha_nibbles = in_alpha_nibbles;
    q_entry.selector_bits = in_selector_bits;
    q_entry.r0 = atc_pkg::widen5(in_endpoint_zero[14:10]);
    q_entry.g0 = atc_pkg::widen5(in_endpoint_zero[9:5]);
    q_entry.b0 = atc_pkg::widen5(in_endpoint_zero[4:0]);
    q_entry.r1 = atc_pkg::widen5(in_endpoint_one[15:11]);
    q_entry.g1 = atc_pkg::widen6(in_endpoint_one[10:5]);
    q_entry.b1 = atc_pkg::widen5(in_endpoint_one[4:0]);
    q_entry.mask = mask;
    q_entry.base_x = atc_pkg::COORD_W'(XW'({col_r, 2'b00}));
    q_entry.base_y = atc_pkg::COORD_W'(XW'({row_r, 2'b00}));
    q_entry.explicit_alpha = amode_r;
  end

endmodule
`default_nettype wire

// ===== sv/atc_queue.sv =====
// short block queue between front and back
`default_nettype none
module atc_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire atc_pkg::blk_entry_t push_entry,
  input  wire logic                pop,
  output logic                     full,
  output logic                     empty,
  output atc_pkg::blk_entry_t      head
);

  localparam int QD = atc_pkg::QUEUE_DEPTH;
  localparam int PW = (QD > 1) ? $clog2(QD) : 1;
  localparam int CW = $clog2(QD + 1);

  atc_pkg::blk_entry_t entries_r [QD];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full = (count_r == CW'(QD));
  assign empty = (count_r == '0);
  assign head = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QD - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QD - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) count_nxt = count_r + CW'(1);
    else if (pop && !push) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries_r[wr_ptr_r] <= push_entry;
  end

endmodule
`default_nettype wire

// ===== sv/atc_back.sv =====
// back end: walks the head block's mask, one texel a cycle unless stalled
`default_nettype none
module atc_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_empty,
  input  wire atc_pkg::blk_entry_t head,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [11:0]              out_texel_x,
  output logic [11:0]              out_texel_y,
  output logic [7:0]               out_red,
  output logic [7:0]               out_green,
  output logic [7:0]               out_blue,
  output logic [7:0]               out_alpha,
  output logic                     out_last_of_block
);

  localparam int T = atc_pkg::TEXELS;

  logic [T-1:0] done_r, done_nxt;
  logic [T-1:0] rem, pick, rem_after;
  logic [3:0]   idx;
  logic [1:0]   sel;
  logic [3:0]   nib;
  logic         fire, last;
  logic         out_valid_r, out_valid_nxt;
  logic [11:0]  x_r, y_r;
  logic [7:0]   red_r, green_r, blue_r, alpha_r;
  logic         last_r;

  assign rem = head.mask & ~done_r;
  assign pick = rem & (~rem + T'(1));
  assign rem_after = rem & ~pick;
  assign last = (rem_after == '0);

  always_comb begin
    idx = '0;
    for (int k = 0; k < T; k++) begin
      if (pick[k]) idx = 4'(k);
    end
  end

  assign sel = head.selector_bits[{idx, 1'b0} +: 2];
  assign nib = head.alpha_nibbles[{idx, 2'b00} +: 4];

  assign fire = !q_empty && (!out_valid_r || out_ready);
  assign q_pop = fire && last;

  always_comb begin
    done_nxt = done_r;
    out_valid_nxt = out_valid_r;
    if (fire) begin
      done_nxt = last ? '0 : (done_r | pick);
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      x_r <= head.base_x | 12'(idx[1:0]);
      y_r <= head.base_y | 12'(idx[3:2]);
      red_r <= atc_pkg::blend(head.r0, head.r1, sel);
      green_r <= atc_pkg::blend(head.g0, head.g1, sel);
      blue_r <= atc_pkg::blend(head.b0, head.b1, sel);
      alpha_r <= head.explicit_alpha ? 8'(8'(nib) * atc_pkg::ALPHA_SCALE)
                                     : atc_pkg::ALPHA_OPAQUE;
      last_r <= last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_texel_x = x_r;
  assign out_texel_y = y_r;
  assign out_red = red_r;
  assign out_green = green_r;
  assign out_blue = blue_r;
  assign out_alpha = alpha_r;
  assign out_last_of_block = last_r;

endmodule
`default_nettype wire

// ===== sv/atc_texture_block_decoder.sv =====
// top level of the atc 4x4 texture block decoder
// a taken block is written into the queue; the back end registers each texel it emits
// throughput: one texel per cycle from the back end while not stalled by out_ready
// or an empty queue; a fully clipped block is taken at the input but never queued
// a two-entry block queue lets the front take new blocks while the back emits texels
// reset (synchronous, rst_n low): block counters zero, 4x4 image, opaque alpha, queue empty
`default_nettype none
module atc_texture_block_decoder #(
  parameter int MAX_DIMENSION = atc_pkg::MAX_DIMENSION_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] in_alpha_nibbles,
  input  wire logic [15:0] in_endpoint_zero,
  input  wire logic [15:0] in_endpoint_one,
  input  wire logic [31:0] in_selector_bits,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [11:0]      out_texel_x,
  output logic [11:0]      out_texel_y,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic [7:0]       out_alpha,
  output logic             out_last_of_block
);

  atc_pkg::cfg_wr_t    cfg;
  atc_pkg::blk_entry_t push_entry, head;
  logic                q_push, q_pop, q_full, q_empty;

  assign cfg.we = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.wdata = cfg_wdata;

  atc_front #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .cfg(cfg),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_alpha_nibbles(in_alpha_nibbles),
    .in_endpoint_zero(in_endpoint_zero),
    .in_endpoint_one(in_endpoint_one),
    .in_selector_bits(in_selector_bits),
    .q_full(q_full),
    .q_push(q_push),
    .q_entry(push_entry)
  );

  atc_queue u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push(q_push),
    .push_entry(push_entry),
    .pop(q_pop),
    .full(q_full),
    .empty(q_empty),
    .head(head)
  );

  atc_back u_back (
    .clk(clk),
    .rst_n(rst_n),
    .q_empty(q_empty),
    .head(head),
    .q_pop(q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_texel_x(out_texel_x),
    .out_texel_y(out_texel_y),
    .out_red(out_red),
    .out_green(out_green),
    .out_blue(out_blue),
    .out_alpha(out_alpha),
    .out_last_of_block(out_last_of_block)
  );

endmodule
`default_nettype wire

// ===== tb/sv/atc_texel_checker.sv =====
`timescale 1ns / 1ps
// texel predictor and output comparator for the atc block decoder testbench
module atc_texel_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [63:0] in_alpha_nibbles,
  input  logic [15:0] in_endpoint_zero,
  input  logic [15:0] in_endpoint_one,
  input  logic [31:0] in_selector_bits,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [11:0] out_texel_x,
  input  logic [11:0] out_texel_y,
  input  logic [7:0]  out_red,
  input  logic [7:0]  out_green,
  input  logic [7:0]  out_blue,
  input  logic [7:0]  out_alpha,
  input  logic        out_last_of_block,
  output int          fail_count,
  output int          pending_texels
);

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  a;
    logic        last;
  } texel_t;

  texel_t      texel_q[$];
  logic [12:0] width_reg;
  logic [12:0] height_reg;
  logic        alpha_mode;
  int unsigned blk_col;
  int unsigned blk_row;
  int          errors = 0;

  function automatic int unsigned fit_dimension(input logic [12:0] d);
    if (d == 13'd0) return 1;
    if (d > atc_pkg::MAX_DIMENSION_DEF) return atc_pkg::MAX_DIMENSION_DEF;
    return d;
  endfunction

  function automatic int unsigned expand5(input logic [4:0] v);
    return int'(v) * 8 + int'(v) / 4;
  endfunction

  function automatic int unsigned expand6(input logic [5:0] v);
    return int'(v) * 4 + int'(v) / 16;
  endfunction

  function automatic logic [7:0] mix(input int unsigned a, input int unsigned b,
                                     input logic [1:0] sel);
    int unsigned m;
    case (sel)
      atc_pkg::SEL_E0:     m = a;
      atc_pkg::SEL_THIRD:  m = (2 * a + b) / 3;
      atc_pkg::SEL_EIGHTH: m = (3 * a + 5 * b) / 8;
      default:             m = b;
    endcase
    return 8'(m);
  endfunction

  task automatic decode_block(input logic [63:0] alpha_bits, input logic [15:0] e0,
                              input logic [15:0] e1, input logic [31:0] sel_bits);
    int unsigned w, h, cols, rows, x, y, k, n, av;
    int unsigned r0, g0, b0, r1, g1, b1;
    logic [1:0]  sel;
    texel_t      t;
    texel_t      blk[16];
    w = fit_dimension(width_reg);
    h = fit_dimension(height_reg);
    cols = (w + 3) / 4;
    rows = (h + 3) / 4;
    r0 = expand5(e0[14:10]);
    g0 = expand5(e0[9:5]);
    b0 = expand5(e0[4:0]);
    r1 = expand5(e1[15:11]);
    g1 = expand6(e1[10:5]);
    b1 = expand5(e1[4:0]);
    n = 0;
    for (k = 0; k < 16; k++) begin
      x = blk_col * 4 + k % 4;
      y = blk_row * 4 + k / 4;
      if (x < w && y < h) begin
        sel = sel_bits[2*k +: 2];
        av = alpha_mode ? alpha_bits[4*k +: 4] * atc_pkg::ALPHA_SCALE
                        : atc_pkg::ALPHA_OPAQUE;
        t.x = 12'(x);
        t.y = 12'(y);
        t.r = mix(r0, r1, sel);
        t.g = mix(g0, g1, sel);
        t.b = mix(b0, b1, sel);
        t.a = 8'(av);
        t.last = 1'b0;
        blk[n] = t;
        n++;
      end
    end
    for (k = 0; k < n; k++) begin
      t = blk[k];
      t.last = (k == n - 1);
      texel_q.push_back(t);
    end
    blk_col++;
    if (blk_col >= cols) begin
      blk_col = 0;
      blk_row++;
      if (blk_row >= rows) blk_row = 0;
    end
  endtask

  task automatic compare_field(input string name, input logic [11:0] want_v,
                               input logic [11:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
      errors++;
    end
  endtask

  task automatic check_texel();
    texel_t want;
    if (texel_q.size() == 0) begin
      $display("%0t: texel (%0d,%0d) expected none, got one", $time, out_texel_x,
               out_texel_y);
      errors++;
    end else begin
      want = texel_q.pop_front();
      compare_field("texel_x", want.x, out_texel_x);
      compare_field("texel_y", want.y, out_texel_y);
      compare_field("red", want.r, out_red);
      compare_field("green", want.g, out_green);
      compare_field("blue", want.b, out_blue);
      compare_field("alpha", want.a, out_alpha);
      compare_field("last_of_block", want.last, out_last_of_block);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg = 13'd4;
      height_reg = 13'd4;
      alpha_mode = 1'b0;
      blk_col = 0;
      blk_row = 0;
      texel_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          atc_pkg::CFG_IMAGE_WIDTH:  width_reg = cfg_wdata;
          atc_pkg::CFG_IMAGE_HEIGHT: height_reg = cfg_wdata;
          atc_pkg::CFG_ALPHA_MODE:   alpha_mode = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        decode_block(in_alpha_nibbles, in_endpoint_zero, in_endpoint_one, in_selector_bits);
      end
      if (out_valid && out_ready) begin
        check_texel();
      end
    end
    fail_count <= errors;
    pending_texels <= texel_q.size();
  end

endmodule

// ===== tb/sv/atc_texture_block_decoder_tb.sv =====
`timescale 1ns / 1ps
// top of the atc block decoder testbench: clock, reset, block requests and verdict
module atc_texture_block_decoder_tb;

  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int HOLD_PHASE = 1;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [12:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] in_alpha_nibbles = '0;
  logic [15:0] in_endpoint_zero = '0;
  logic [15:0] in_endpoint_one = '0;
  logic [31:0] in_selector_bits = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [11:0] out_texel_x;
  logic [11:0] out_texel_y;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_alpha;
  logic        out_last_of_block;

  int   fail_count;
  int   pending_texels;
  int   phase = 0;
  logic calm = 1'b0;
  int   hold_left = 0;
  logic hold_done = 1'b0;
  int   cycle_count = 0;

  always #5 clk = ~clk;

  atc_texture_block_decoder u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_alpha_nibbles (in_alpha_nibbles),
    .in_endpoint_zero (in_endpoint_zero),
    .in_endpoint_one  (in_endpoint_one),
    .in_selector_bits (in_selector_bits),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_texel_x      (out_texel_x),
    .out_texel_y      (out_texel_y),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_alpha        (out_alpha),
    .out_last_of_block(out_last_of_block)
  );

  atc_texel_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_alpha_nibbles (in_alpha_nibbles),
    .in_endpoint_zero (in_endpoint_zero),
    .in_endpoint_one  (in_endpoint_one),
    .in_selector_bits (in_selector_bits),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_texel_x      (out_texel_x),
    .out_texel_y      (out_texel_y),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_alpha        (out_alpha),
    .out_last_of_block(out_last_of_block),
    .fail_count       (fail_count),
    .pending_texels   (pending_texels)
  );

  // texel sink, with one long hold-off so the block queue fills and stalls requests
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (phase == HOLD_PHASE && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 10);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[atc_texture_block_decoder] ERROR");
      $finish;
    end
  end

  task automatic send_block(input logic [63:0] alpha_bits, input logic [15:0] e0,
                            input logic [15:0] e1, input logic [31:0] sel_bits);
    while (!calm && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_alpha_nibbles <= alpha_bits;
    in_endpoint_zero <= e0;
    in_endpoint_one <= e1;
    in_selector_bits <= sel_bits;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [15:0] pick_endpoint();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_texels != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_we high, the caller lowers it after the last write
  task automatic write_reg(input logic [1:0] idx, input logic [12:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic reconfigure(input logic [12:0] w, input logic [12:0] h, input logic amode);
    settle();
    write_reg(atc_pkg::CFG_IMAGE_WIDTH, w);
    write_reg(atc_pkg::CFG_IMAGE_HEIGHT, h);
    write_reg(atc_pkg::CFG_ALPHA_MODE, {12'd0, amode});
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int id, input logic quiet, input int count);
    phase <= id;
    calm <= quiet;
    repeat (count) begin
      send_block({$urandom, $urandom}, pick_endpoint(), pick_endpoint(), $urandom);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // opaque 4x4 image, every selector and endpoint extremes
    send_block(64'hFFFF_FFFF_FFFF_FFFF, 16'h0000, 16'hFFFF, 32'h0000_0000);
    send_block(64'h0000_0000_0000_0000, 16'h0000, 16'hFFFF, 32'h5555_5555);
    send_block({$urandom, $urandom}, 16'h0000, 16'hFFFF, 32'hAAAA_AAAA);
    send_block({$urandom, $urandom}, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF);
    send_block({$urandom, $urandom}, 16'hFFFF, 16'h0000, 32'hE4E4_E4E4);
    send_block({$urandom, $urandom}, 16'h7FFF, 16'h07E0, 32'h1B1B_1B1B);
    // top bit of endpoint zero carries no meaning
    send_block({$urandom, $urandom}, 16'h8000, 16'hFFFF, 32'hE4E4_E4E4);

    reconfigure(13'd4, 13'd4, 1'b1);
    send_block(64'h0000_0000_0000_0000, 16'h1234, 16'hABCD, 32'hE4E4_E4E4);
    send_block(64'hFFFF_FFFF_FFFF_FFFF, 16'h5A5A, 16'hA5A5, 32'h1B1B_1B1B);
    send_block(64'h0123_4567_89AB_CDEF, 16'hFFFF, 16'h0000, 32'hE4E4_E4E4);
    send_block(64'hFEDC_BA98_7654_3210, 16'h0000, 16'hFFFF, 32'h4E4E_4E4E);

    // zero size reads as one texel, spare index is ignored
    settle();
    write_reg(atc_pkg::CFG_IMAGE_WIDTH, 13'd0);
    write_reg(atc_pkg::CFG_IMAGE_HEIGHT, 13'd0);
    write_reg(CFG_SPARE, 13'h1FFF);
    cfg_we <= 1'b0;
    send_block({$urandom, $urandom}, pick_endpoint(), pick_endpoint(), $urandom);
    send_block({$urandom, $urandom}, pick_endpoint(), pick_endpoint(), $urandom);

    // oversize reads as the maximum dimension
    reconfigure(13'h1FFF, 13'd4097, 1'b0);
    send_block({$urandom, $urandom}, pick_endpoint(), pick_endpoint(), $urandom);
    send_block({$urandom, $urandom}, pick_endpoint(), pick_endpoint(), $urandom);

    // partial blocks on both edges, then wrap
    reconfigure(13'd5, 13'd6, 1'b1);
    repeat (5) begin
      send_block({$urandom, $urandom}, pick_endpoint(), pick_endpoint(), $urandom);
    end

    reconfigure(13'd13, 13'd9, 1'b1);
    run_phase(HOLD_PHASE, 1'b0, 30);
    reconfigure(13'd1, 13'd4096, 1'b0);
    run_phase(2, 1'b0, 10);
    reconfigure(13'd64, 13'd64, 1'b1);
    run_phase(3, 1'b0, 20);
    // shrink with the counters left beyond the new image
    reconfigure(13'd12, 13'd4, 1'b0);
    run_phase(4, 1'b0, 10);
    reconfigure(13'($urandom_range(1, 40)), 13'($urandom_range(1, 40)),
                1'($urandom_range(0, 1)));
    run_phase(5, 1'b0, 15);
    // 4095 texels wide and one high, no idling on either side
    reconfigure(13'd4095, 13'd1, 1'b1);
    run_phase(6, 1'b1, 25);
    reconfigure(13'd7, 13'd3, 1'b1);
    run_phase(7, 1'b0, 10);

    settle();
    if (fail_count == 0) begin
      $display("[atc_texture_block_decoder] OK");
    end else begin
      $display("[atc_texture_block_decoder] ERROR");
    end
    $finish;
  end

endmodule

// ===== atc_texture_block_decoder.f =====
sv/atc_pkg.sv
sv/atc_front.sv
sv/atc_queue.sv
sv/atc_back.sv
sv/atc_texture_block_decoder.sv
tb/sv/atc_texel_checker.sv
tb/sv/atc_texture_block_decoder_tb.sv
